// ----- rtl/core/mhor_pkg.sv -----
// ----------------------------------------------------------------------------
// mhor_pkg
// shared types and constants of the owner-removal min-heap
// ----------------------------------------------------------------------------
`default_nettype none
package mhor_pkg;
    localparam int DEPTH      = 64;
    localparam int KEY_BITS   = 32;
    localparam int OWNER_BITS = 8;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,      // capture request, write push slot
        CMD_SCAN_RD,   // read slot at pos
        CMD_SCAN_CHK,  // compare owner, advance pos
        CMD_MOVE_RD,   // read last slot
        CMD_MOVE_WR,   // write last into pos
        CMD_UP_RD,     // read parent of pos
        CMD_UP_CHK,    // compare cur with parent, swap
        CMD_DN_RD1,    // read first child
        CMD_DN_RD2,    // read second child
        CMD_DN_CHK,    // compare and swap
        CMD_PUT,       // write cur into pos
        CMD_ROOT_RD,   // read root
        CMD_ROOT_CAP   // capture root
    } cmd_t;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic match;        // scanned owner matches
        logic scan_end;     // pos is past the last entry
        logic at_last;      // removed slot is the last slot
        logic at_root;      // pos is zero
        logic up_swap;      // cur key below parent key
        logic has_child;
        logic dn_swap;
    } status_t;
endpackage
`default_nettype wire

// ----- rtl/core/min_heap_with_owner_removal.sv -----
// ----------------------------------------------------------------------------
// min_heap_with_owner_removal
// binary min-heap of (key, owner) requests with removal by owner tag
// ----------------------------------------------------------------------------
// One item in, one result out. A push rises level by level from its new
// slot. A removal scans the owners slot by slot (one memory read and compare
// per slot), then the entry moved into the freed slot rises or sinks level
// by level. Each step goes through the heap memory, and a stalled result
// adds its wait. No new item is taken until the result has moved into the
// output register.
`default_nettype none
module min_heap_with_owner_removal
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            operation,
    input  wire logic [mhor_pkg::OWNER_BITS-1:0] owner,
    input  wire logic [mhor_pkg::KEY_BITS-1:0]   key,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           status,
    output logic [mhor_pkg::CNT_BITS-1:0]        count,
    output logic                                 top_valid,
    output logic [mhor_pkg::OWNER_BITS-1:0]      top_owner,
    output logic [mhor_pkg::KEY_BITS-1:0]        top_key
);
    mhor_pkg::cmd_t    cmd;
    mhor_pkg::status_t stat;
    logic              busy;
    logic              res_load;
    logic [1:0]        res_status;
    logic              in_fire;
    logic              out_free;
    logic [mhor_pkg::CNT_BITS-1:0]   fill;
    logic [mhor_pkg::OWNER_BITS-1:0] root_owner;
    logic [mhor_pkg::KEY_BITS-1:0]   root_key;
    logic                            out_valid_reg;

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    assign out_free = !out_valid_reg || !out_stall;

    mhor_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .out_free   (out_free),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .res_load   (res_load),
        .res_status (res_status)
    );

    mhor_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op_in      (operation),
        .owner_in   (owner),
        .key_in     (key),
        .stat       (stat),
        .fill       (fill),
        .root_owner (root_owner),
        .root_key   (root_key)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status    <= res_status;
            count     <= fill;
            top_valid <= fill != '0;
            top_owner <= root_owner;
            top_key   <= root_key;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ----- rtl/core/mhor_ctrl.sv -----
// ----------------------------------------------------------------------------
// mhor_ctrl
// sequencer for push, scan, move and sift steps of the heap
// ----------------------------------------------------------------------------
`default_nettype none
module mhor_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              out_free,
    input  wire mhor_pkg::status_t stat,
    output mhor_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   res_load,
    output logic [1:0]             res_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_MOVE_RD, S_MOVE_WR, S_UP_RD, S_UP_CHK,
        S_DN_RD1, S_DN_RD2, S_DN_CHK, S_ROOT_RD, S_ROOT_CAP, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] stat_reg, stat_next;

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd        = mhor_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd        = mhor_pkg::CMD_LOAD;
                    stat_next  = mhor_pkg::ST_DONE;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                // after load and after each owner mismatch: decide the operation, end the scan or read a slot
                if (!stat.is_remove)
                begin
                    if (stat.full)
                    begin
                        stat_next  = mhor_pkg::ST_FULL;
                        state_next = S_ROOT_RD;
                    end
                    else
                        state_next = S_UP_RD;
                end
                else if (stat.scan_end)
                begin
                    stat_next  = mhor_pkg::ST_NOT_FOUND;
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    cmd        = mhor_pkg::CMD_SCAN_RD;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd = mhor_pkg::CMD_SCAN_CHK;
                if (stat.match)
                    state_next = S_MOVE_RD;
                else
                    state_next = S_SCAN_RD;
            end
            S_MOVE_RD:
            begin
                cmd = mhor_pkg::CMD_MOVE_RD;
                if (stat.at_last)
                    state_next = S_ROOT_RD;
                else
                    state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd        = mhor_pkg::CMD_MOVE_WR;
                state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (stat.at_root)
                begin
                    // entry settles at the root
                    cmd        = mhor_pkg::CMD_PUT;
                    state_next = stat.is_remove ? S_DN_RD1 : S_ROOT_RD;
                end
                else
                begin
                    cmd        = mhor_pkg::CMD_UP_RD;
                    state_next = S_UP_CHK;
                end
            end
            S_UP_CHK:
            begin
                cmd = mhor_pkg::CMD_UP_CHK;
                if (stat.up_swap)
                    state_next = S_UP_RD;
                else if (stat.is_remove && stat.dn_swap)
                    state_next = S_DN_RD1;   // dn_swap marks no rise happened yet
                else
                    state_next = S_ROOT_RD;
            end
            S_DN_RD1:
            begin
                if (!stat.has_child)
                begin
                    cmd        = mhor_pkg::CMD_PUT;
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    cmd        = mhor_pkg::CMD_DN_RD1;
                    state_next = S_DN_RD2;
                end
            end
            S_DN_RD2:
            begin
                cmd        = mhor_pkg::CMD_DN_RD2;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                cmd        = mhor_pkg::CMD_DN_CHK;
                state_next = stat.dn_swap ? S_DN_RD1 : S_ROOT_RD;
            end
            S_ROOT_RD:
            begin
                cmd        = mhor_pkg::CMD_ROOT_RD;
                state_next = S_ROOT_CAP;
            end
            S_ROOT_CAP:
            begin
                cmd        = mhor_pkg::CMD_ROOT_CAP;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign res_load   = (state_reg == S_OUT) && out_free;
    assign res_status = stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= mhor_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    a_out_after_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT_CAP |=> state_reg == S_OUT)
        else $error("root capture not followed by result");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == mhor_pkg::CMD_LOAD |-> $past(state_reg) != S_IDLE || state_reg == S_IDLE)
        else $error("load outside idle");
    a_res_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> state_reg == S_IDLE)
        else $error("result load did not return to idle");
endmodule
`default_nettype wire

// ----- rtl/core/mhor_dp.sv -----
// ----------------------------------------------------------------------------
// mhor_dp
// heap memory, position registers, compares and fill count
// ----------------------------------------------------------------------------
`default_nettype none
module mhor_dp
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mhor_pkg::cmd_t                  cmd,
    input  wire logic                            op_in,
    input  wire logic [mhor_pkg::OWNER_BITS-1:0] owner_in,
    input  wire logic [mhor_pkg::KEY_BITS-1:0]   key_in,
    output mhor_pkg::status_t                    stat,
    output logic [mhor_pkg::CNT_BITS-1:0]        fill,
    output logic [mhor_pkg::OWNER_BITS-1:0]      root_owner,
    output logic [mhor_pkg::KEY_BITS-1:0]        root_key
);
    localparam int EW = mhor_pkg::KEY_BITS + mhor_pkg::OWNER_BITS;
    localparam int IW = mhor_pkg::IDX_BITS;
    localparam int CW = mhor_pkg::CNT_BITS;

    logic [EW-1:0] mem [mhor_pkg::DEPTH];
    logic [EW-1:0] rd_reg;

    logic                            op_reg;
    logic [mhor_pkg::OWNER_BITS-1:0] owner_reg;
    logic [EW-1:0]                   cur_reg;    // entry being sifted
    logic [EW-1:0]                   oth_reg;    // first child
    logic [CW-1:0]                   pos_reg;    // wide enough to reach fill
    logic [CW-1:0]                   oth_pos_reg;
    logic [CW-1:0]                   fill_reg;
    logic                            first_reg;  // sift-up not yet moved
    logic [CW-1:0]                   child1;
    logic [CW-1:0]                   parent;
    logic [CW-1:0]                   last;
    logic [mhor_pkg::OWNER_BITS-1:0] root_owner_reg;
    logic [mhor_pkg::KEY_BITS-1:0]   root_key_reg;

    logic          we;
    logic [IW-1:0] wa;
    logic [EW-1:0] wd;
    logic [IW-1:0] ra;

    function automatic logic [mhor_pkg::KEY_BITS-1:0] key_of(input logic [EW-1:0] e);
        key_of = e[EW-1:mhor_pkg::OWNER_BITS];
    endfunction

    assign child1 = CW'({pos_reg, 1'b1});
    assign parent = (pos_reg - CW'(1)) >> 1;
    assign last   = fill_reg - CW'(1);

    always_comb
    begin
        we = 1'b0;
        wa = pos_reg[IW-1:0];
        wd = cur_reg;
        ra = pos_reg[IW-1:0];
        unique case (cmd)
            mhor_pkg::CMD_LOAD:
            begin
                we = (op_in == mhor_pkg::OP_PUSH) && (fill_reg < CW'(mhor_pkg::DEPTH));
                wa = fill_reg[IW-1:0];
                wd = {key_in, owner_in};
            end
            mhor_pkg::CMD_MOVE_RD: ra = last[IW-1:0];
            mhor_pkg::CMD_MOVE_WR:
            begin
                we = 1'b1;
                wd = rd_reg;
            end
            mhor_pkg::CMD_UP_RD:   ra = parent[IW-1:0];
            mhor_pkg::CMD_UP_CHK:
            begin
                // parent moves down into pos, or cur settles at pos
                we = 1'b1;
                wd = (key_of(cur_reg) < key_of(rd_reg)) ? rd_reg : cur_reg;
            end
            mhor_pkg::CMD_DN_RD1:  ra = child1[IW-1:0];
            mhor_pkg::CMD_DN_RD2:  ra = IW'(child1 + CW'(1));
            mhor_pkg::CMD_DN_CHK:
            begin
                we = 1'b1;
                wa = oth_pos_reg[IW-1:0];
                wd = cur_reg;
            end
            mhor_pkg::CMD_PUT:     we = 1'b1;
            mhor_pkg::CMD_ROOT_RD: ra = '0;
            default: ;
        endcase
    end

    // dn_chk: choose best child from oth_reg (first) and rd_reg (second)
    logic           second_ok;
    logic           take_second;
    logic [EW-1:0]  best;
    logic [CW-1:0]  best_pos;
    logic           dn_go;
    assign second_ok   = (child1 + CW'(1)) < fill_reg;
    assign take_second = second_ok && (key_of(rd_reg) < key_of(oth_reg));
    assign best        = take_second ? rd_reg : oth_reg;
    assign best_pos    = take_second ? child1 + CW'(1) : child1;
    assign dn_go       = key_of(best) < key_of(cur_reg);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= (cmd == mhor_pkg::CMD_DN_CHK) ? (dn_go ? best : cur_reg) : wd;
        rd_reg <= mem[ra];
    end

    // the down swap writes best into pos and cur into best slot, over two writes:
    // best goes to pos here, cur is written at the next step or at the end
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            mhor_pkg::CMD_LOAD:
            begin
                op_reg    <= op_in;
                owner_reg <= owner_in;
                cur_reg   <= {key_in, owner_in};
                pos_reg   <= (op_in == mhor_pkg::OP_PUSH) ? fill_reg : '0;
                first_reg <= 1'b1;
            end
            mhor_pkg::CMD_SCAN_CHK:
            begin
                if (rd_reg[mhor_pkg::OWNER_BITS-1:0] != owner_reg)
                    pos_reg <= pos_reg + CW'(1);
            end
            mhor_pkg::CMD_MOVE_WR: cur_reg <= rd_reg;
            mhor_pkg::CMD_UP_CHK:
            begin
                if (key_of(cur_reg) < key_of(rd_reg))
                begin
                    pos_reg   <= parent;
                    first_reg <= 1'b0;
                end
            end
            mhor_pkg::CMD_DN_RD2:
            begin
                oth_reg     <= rd_reg;
                oth_pos_reg <= pos_reg;
            end
            mhor_pkg::CMD_DN_CHK:
            begin
                if (dn_go)
                    pos_reg <= best_pos;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (cmd == mhor_pkg::CMD_LOAD && op_in == mhor_pkg::OP_PUSH
                 && fill_reg < CW'(mhor_pkg::DEPTH))
            fill_reg <= fill_reg + CW'(1);
        else if (cmd == mhor_pkg::CMD_MOVE_RD)
            fill_reg <= last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd == mhor_pkg::CMD_ROOT_CAP)
        begin
            root_owner_reg <= (fill_reg != '0) ? rd_reg[mhor_pkg::OWNER_BITS-1:0] : '0;
            root_key_reg   <= (fill_reg != '0) ? key_of(rd_reg) : '0;
        end
    end

    assign stat.is_remove = op_reg;
    // a push holds the fill count seen at load in pos
    assign stat.full      = (pos_reg == CW'(mhor_pkg::DEPTH));
    assign stat.empty     = (fill_reg == '0);
    assign stat.match     = rd_reg[mhor_pkg::OWNER_BITS-1:0] == owner_reg;
    assign stat.scan_end  = pos_reg >= fill_reg;
    assign stat.at_last   = pos_reg == last;
    assign stat.at_root   = pos_reg == '0;
    assign stat.up_swap   = key_of(cur_reg) < key_of(rd_reg);
    assign stat.has_child = child1 < fill_reg;
    assign stat.dn_swap   = (cmd == mhor_pkg::CMD_UP_CHK) ? first_reg : dn_go;

    assign fill       = fill_reg;
    assign root_owner = root_owner_reg;
    assign root_key   = root_key_reg;

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(mhor_pkg::DEPTH))
        else $error("fill count above depth");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != $past(fill_reg) |-> fill_reg == $past(fill_reg) + CW'(1)
        || fill_reg == $past(fill_reg) - CW'(1))
        else $error("fill count jumped");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == mhor_pkg::CMD_DN_CHK |-> pos_reg < fill_reg)
        else $error("sift position out of range");
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// min-heap with owner removal: directed and random pushes and removals,
// checked against a behavioral heap model under varied idle and stall phases
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    typedef struct packed {
        logic                            op;
        logic [mhor_pkg::OWNER_BITS-1:0] own;
        logic [mhor_pkg::KEY_BITS-1:0]   k;
    } request_t;

    typedef struct packed {
        logic [1:0]                      st;
        logic [mhor_pkg::CNT_BITS-1:0]   cnt;
        logic                            tv;
        logic [mhor_pkg::OWNER_BITS-1:0] town;
        logic [mhor_pkg::KEY_BITS-1:0]   tkey;
    } heap_view_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic operation;
    logic [mhor_pkg::OWNER_BITS-1:0] owner;
    logic [mhor_pkg::KEY_BITS-1:0] key;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [mhor_pkg::CNT_BITS-1:0] count;
    logic top_valid;
    logic [mhor_pkg::OWNER_BITS-1:0] top_owner;
    logic [mhor_pkg::KEY_BITS-1:0] top_key;

    min_heap_with_owner_removal DUT
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .owner(owner), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .count(count), .top_valid(top_valid), .top_owner(top_owner),
        .top_key(top_key)
    );

    request_t   pending_reqs[$];
    heap_view_t expected_views[$];

    logic [mhor_pkg::KEY_BITS-1:0]   heap_key[mhor_pkg::DEPTH];
    logic [mhor_pkg::OWNER_BITS-1:0] heap_own[mhor_pkg::DEPTH];
    int heap_fill;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  errors;
    int  accepted;
    int  results;
    longint cycles;
    bit  stim_done;

    function automatic void slot_swap(int p, int q);
        logic [mhor_pkg::KEY_BITS-1:0] tk;
        logic [mhor_pkg::OWNER_BITS-1:0] to;
        tk = heap_key[p]; to = heap_own[p];
        heap_key[p] = heap_key[q]; heap_own[p] = heap_own[q];
        heap_key[q] = tk; heap_own[q] = to;
    endfunction

    function automatic void sift_up(int pos);
        int par;
        while (pos > 0)
        begin
            par = (pos - 1) / 2;
            if (heap_key[pos] < heap_key[par])
            begin
                slot_swap(pos, par);
                pos = par;
            end
            else
                break;
        end
    endfunction

    function automatic void sift_down(int pos);
        int best;
        while (2 * pos + 1 < heap_fill)
        begin
            best = 2 * pos + 1;
            if (best + 1 < heap_fill && heap_key[best + 1] < heap_key[best])
                best = best + 1;
            if (heap_key[best] < heap_key[pos])
            begin
                slot_swap(best, pos);
                pos = best;
            end
            else
                break;
        end
    endfunction

    function automatic heap_view_t apply_request(request_t r);
        heap_view_t v;
        int i;
        v = '0;
        if (r.op == mhor_pkg::OP_PUSH)
        begin
            if (heap_fill >= mhor_pkg::DEPTH)
                v.st = mhor_pkg::ST_FULL;
            else
            begin
                heap_key[heap_fill] = r.k;
                heap_own[heap_fill] = r.own;
                heap_fill++;
                sift_up(heap_fill - 1);
                v.st = mhor_pkg::ST_DONE;
            end
        end
        else
        begin
            i = 0;
            while (i < heap_fill && heap_own[i] != r.own)
                i++;
            if (i >= heap_fill)
                v.st = mhor_pkg::ST_NOT_FOUND;
            else
            begin
                v.st = mhor_pkg::ST_DONE;
                heap_fill--;
                if (i != heap_fill)
                begin
                    heap_key[i] = heap_key[heap_fill];
                    heap_own[i] = heap_own[heap_fill];
                    if (i > 0 && heap_key[i] < heap_key[(i - 1) / 2])
                        sift_up(i);
                    else
                        sift_down(i);
                end
            end
        end
        v.cnt = heap_fill[mhor_pkg::CNT_BITS-1:0];
        if (heap_fill > 0)
        begin
            v.tv = 1'b1;
            v.town = heap_own[0];
            v.tkey = heap_key[0];
        end
        return v;
    endfunction

    function automatic request_t make_req(logic op, logic [mhor_pkg::OWNER_BITS-1:0] o,
                                          logic [mhor_pkg::KEY_BITS-1:0] k);
        request_t r;
        r.op = op; r.own = o; r.k = k;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= 1'b0;
            owner     <= '0;
            key       <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_views.push_back(apply_request(
                    make_req(operation, owner, key)));
                accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    in_valid  <= 1'b1;
                    operation <= r.op;
                    owner     <= r.own;
                    key       <= r.k;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                heap_view_t e;
                results++;
                if (expected_views.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_views.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status expected %0d actual %0d", e.st, status);
                        errors++;
                    end
                    if (count !== e.cnt)
                    begin
                        $error("count expected %0d actual %0d", e.cnt, count);
                        errors++;
                    end
                    if (top_valid !== e.tv)
                    begin
                        $error("top_valid expected %0d actual %0d", e.tv, top_valid);
                        errors++;
                    end
                    if (top_owner !== e.town)
                    begin
                        $error("top_owner expected %0d actual %0d", e.town, top_owner);
                        errors++;
                    end
                    if (top_key !== e.tkey)
                    begin
                        $error("top_key expected %0h actual %0h", e.tkey, top_key);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("FAIL min_heap_with_owner_removal");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_views.size() > 0)
            @(posedge clk);
    endtask

    task automatic add_random(int n);
        int j;
        int ov;
        logic [mhor_pkg::OWNER_BITS-1:0] o;
        logic [mhor_pkg::KEY_BITS-1:0] kv;
        // a small owner pool keeps removals hitting; the push share alternates
        // every 150 items so the heap swings between empty and full
        for (j = 0; j < n; j++)
        begin
            ov = (($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(15));
            o = ov[mhor_pkg::OWNER_BITS-1:0];
            case ($urandom_range(3))
                0: kv = $urandom;
                1: kv = $urandom_range(7);
                2: kv = 32'hFFFF_FFF0 | $urandom_range(15);
                default: kv = $urandom_range(1000);
            endcase
            if ((j / 150) % 2 == 0 ? ($urandom_range(99) < 70) : ($urandom_range(99) < 30))
                pending_reqs.push_back(make_req(mhor_pkg::OP_PUSH, o, kv));
            else
                pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, o, $urandom));
        end
    endtask

    initial
    begin
        int ph;
        errors = 0; accepted = 0; results = 0; cycles = 0;
        heap_fill = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        in_valid = 1'b0; operation = 1'b0; owner = '0; key = '0; out_stall = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty removal, extremes, equal keys, last-slot removal, full heap
        pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, 8'd0, 32'd0));
        pending_reqs.push_back(make_req(mhor_pkg::OP_PUSH, 8'hFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(mhor_pkg::OP_PUSH, 8'h00, 32'h0));
        pending_reqs.push_back(make_req(mhor_pkg::OP_PUSH, 8'h55, 32'h0));
        pending_reqs.push_back(make_req(mhor_pkg::OP_PUSH, 8'hAA, 32'h5555_AAAA));
        pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, 8'hAA, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, 8'h77, 32'd0));
        pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, 8'h00, 32'd0));
        pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, 8'hFF, 32'd0));
        pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, 8'h55, 32'd0));
        for (int j = 0; j < mhor_pkg::DEPTH + 2; j++)
            pending_reqs.push_back(make_req(mhor_pkg::OP_PUSH, j[7:0], mhor_pkg::DEPTH - j));
        for (int j = 0; j < mhor_pkg::DEPTH; j++)
            pending_reqs.push_back(make_req(mhor_pkg::OP_REMOVE, j[7:0] ^ 8'h15, 32'd0));
        wait_drained();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            add_random(360);
            wait_drained();
        end
        recv_stall_pct = 0;
        repeat (400) @(posedge clk);

        $display("covered %0d items and %0d results over five idle and stall phases",
                 accepted, results);
        if (errors == 0 && expected_views.size() == 0)
            $display("PASS min_heap_with_owner_removal");
        else
            $display("FAIL min_heap_with_owner_removal");
        $finish;
    end
endmodule
`default_nettype wire
